FILE: hdl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared property wrappers for the reduction stack blocks.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/rms_pkg.sv
// ============================================================================
// rms_pkg
// Field widths, operation and error codes, and control types for the stack.
// ============================================================================
package rms_pkg;

    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_REF_WIDTH   = 32;

    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int AMT_W   = 9;
    localparam int DEPTH_W = 9;
    localparam int ERR_W   = 2;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_N = 3'd3;
    localparam logic [OP_W-1:0] OP_SLIDE = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic finish;   // load the result register this cycle
    } t_cmd;

endpackage

FILE: hdl/rms_dpath.sv
// ============================================================================
// rms_dpath
// Stack memory, entry count, bounds checks and the result register.
// ============================================================================
`include "assert_macros.svh"

module rms_dpath #(
    parameter int STACK_DEPTH = rms_pkg::DEF_STACK_DEPTH,
    parameter int REF_WIDTH   = rms_pkg::DEF_REF_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rms_pkg::t_cmd               i_cmd,
    input  logic [rms_pkg::OP_W-1:0]    i_opcode,
    input  logic [rms_pkg::VAL_W-1:0]   i_node_ref,
    input  logic [rms_pkg::AMT_W-1:0]   i_amount,
    output logic [rms_pkg::VAL_W-1:0]   o_read_value,
    output logic [rms_pkg::DEPTH_W-1:0] o_depth_now,
    output logic [rms_pkg::ERR_W-1:0]   o_error_code
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > rms_pkg::AMT_W) ? CNT_W : rms_pkg::AMT_W) + 1;

    logic [REF_WIDTH-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [REF_WIDTH-1:0]      r_rd_data;
    logic [rms_pkg::ERR_W-1:0] r_err;
    logic [rms_pkg::ERR_W-1:0] n_err;
    logic                      r_use_rd;
    logic                      n_use_rd;
    logic                      r_slide_we;
    logic                      n_slide_we;
    logic [IDX_W-1:0]          r_slide_addr;
    logic [IDX_W-1:0]          n_slide_addr;

    logic [rms_pkg::VAL_W-1:0]   r_out_value;
    logic [rms_pkg::DEPTH_W-1:0] r_out_depth;
    logic [rms_pkg::ERR_W-1:0]   r_out_err;

    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] amt_x;
    logic [CMP_W-1:0] below_off;
    logic [IDX_W-1:0] top_idx;
    logic [IDX_W-1:0] free_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             push_we;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [REF_WIDTH-1:0] wr_data;

    assign cnt_x     = CMP_W'(r_count);
    assign amt_x     = CMP_W'(i_amount);
    assign below_off = cnt_x - amt_x - CMP_W'(1);
    assign top_idx   = IDX_W'(r_count - CNT_W'(1));
    assign free_idx  = r_count[IDX_W-1:0];

    // Bounds checks and next state, evaluated on the incoming item.
    always_comb begin
        n_count      = r_count;
        n_err        = rms_pkg::ERR_OK;
        n_use_rd     = 1'b0;
        n_slide_we   = 1'b0;
        n_slide_addr = below_off[IDX_W-1:0];
        rd_en        = 1'b0;
        rd_addr      = top_idx;
        push_we      = 1'b0;
        unique case (i_opcode)
            rms_pkg::OP_PUSH: begin
                if (r_count == CNT_W'(STACK_DEPTH)) begin
                    n_err = rms_pkg::ERR_FULL;
                end else begin
                    push_we = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            rms_pkg::OP_POP: begin
                if (r_count == '0) begin
                    n_err = rms_pkg::ERR_RANGE;
                end else begin
                    rd_en    = 1'b1;
                    n_use_rd = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            rms_pkg::OP_PEEK: begin
                if (amt_x >= cnt_x) begin
                    n_err = rms_pkg::ERR_RANGE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = below_off[IDX_W-1:0];
                    n_use_rd = 1'b1;
                end
            end
            rms_pkg::OP_POP_N: begin
                if (amt_x > cnt_x) begin
                    n_err = rms_pkg::ERR_RANGE;
                end else begin
                    n_count = CNT_W'(cnt_x - amt_x);
                end
            end
            rms_pkg::OP_SLIDE: begin
                if (amt_x >= cnt_x) begin
                    n_err = rms_pkg::ERR_RANGE;
                end else begin
                    rd_en      = 1'b1;
                    n_slide_we = 1'b1;
                    n_count    = CNT_W'(cnt_x - amt_x);
                end
            end
            default: begin
            end
        endcase
    end

    // Push writes on the input transfer; slide writes the fetched top entry
    // when the result is loaded. The two never fall in the same cycle.
    assign wr_en   = (i_cmd.accept && push_we) || (i_cmd.finish && r_slide_we);
    assign wr_addr = i_cmd.finish ? r_slide_addr : free_idx;
    assign wr_data = i_cmd.finish ? r_rd_data : REF_WIDTH'(i_node_ref);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.accept && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_slide_we <= 1'b0;
        end else if (i_cmd.accept) begin
            r_count    <= n_count;
            r_slide_we <= n_slide_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_err        <= n_err;
            r_use_rd     <= n_use_rd;
            r_slide_addr <= n_slide_addr;
        end
        if (i_cmd.finish) begin
            r_out_value <= r_use_rd ? rms_pkg::VAL_W'(r_rd_data) : '0;
            r_out_depth <= rms_pkg::DEPTH_W'(r_count);
            r_out_err   <= r_err;
        end
    end

    assign o_read_value = r_out_value;
    assign o_depth_now  = r_out_depth;
    assign o_error_code = r_out_err;

    `RMS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STACK_DEPTH))
    `RMS_ASSERT_NEXT(a_fail_keeps_count, i_clk, i_rst_n,
        i_cmd.accept && (n_err != rms_pkg::ERR_OK), r_count == $past(r_count))

endmodule

FILE: hdl/rms_ctrl.sv
// ============================================================================
// rms_ctrl
// Sequencer for the accept and finish steps of a stack operation and the result handshake.
// ============================================================================
`include "assert_macros.svh"

module rms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rms_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic accept;
    logic finish;

    assign o_in_stall = (r_state == S_EXEC);
    assign accept     = i_in_valid && !o_in_stall;
    // The result register is free when empty or drained in this cycle.
    assign finish     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.finish = finish;

    `RMS_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, 1'b1, !(accept && finish))
    `RMS_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, accept, r_state == S_EXEC)
    `RMS_ASSERT_NEXT(a_finish_shows, i_clk, i_rst_n, finish, r_out_valid && r_state == S_IDLE)

endmodule

FILE: hdl/reduction_machine_stack.sv
// ============================================================================
// reduction_machine_stack
// Fixed-depth node reference stack with push, pop, peek, pop_n and slide.
// ============================================================================
// Each input transfer has an accept step and a finish step: in the accept
// step the bounds are checked, the entry count is updated and the stack
// memory is read (or, for push, written); in the finish step the registered
// read data is returned and, for slide, written back below the top. The
// stack memory read is synchronous. The result sits in an output register,
// so a new item is taken as soon as the finish step has loaded it, even
// while the previous result is still stalled; the finish step of that new
// item then waits until the output register has drained, and the input is
// stalled meanwhile. A failing operation leaves the stack unchanged.

module reduction_machine_stack #(
    parameter int STACK_DEPTH = rms_pkg::DEF_STACK_DEPTH,
    parameter int REF_WIDTH   = rms_pkg::DEF_REF_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [rms_pkg::OP_W-1:0]    i_opcode,
    input  logic [rms_pkg::VAL_W-1:0]   i_node_ref,
    input  logic [rms_pkg::AMT_W-1:0]   i_amount,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rms_pkg::VAL_W-1:0]   o_read_value,
    output logic [rms_pkg::DEPTH_W-1:0] o_depth_now,
    output logic [rms_pkg::ERR_W-1:0]   o_error_code
);

    rms_pkg::t_cmd cmd;

    rms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    rms_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .REF_WIDTH   (REF_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_node_ref   (i_node_ref),
        .i_amount     (i_amount),
        .o_read_value (o_read_value),
        .o_depth_now  (o_depth_now),
        .o_error_code (o_error_code)
    );

endmodule

FILE: verif/tb_reduction_machine_stack.sv
// ============================================================================
// tb_reduction_machine_stack
// Self-checking testbench for the node reference stack. A queue-fed driver
// and a clocked monitor exercise push, pop, peek, pop_n and slide, including
// the bounds errors and a full stack. Each result is compared with a shadow
// stack that is updated on every accepted input transfer.
// ============================================================================
module tb_reduction_machine_stack;

    localparam int STACK_SIZE   = rms_pkg::DEF_STACK_DEPTH;
    localparam int HOLD_CYCLES  = 64;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 60;

    // Opcodes with no operation behind them.
    localparam logic [rms_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [rms_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [rms_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [rms_pkg::OP_W-1:0]  op;
        logic [rms_pkg::VAL_W-1:0] node;
        logic [rms_pkg::AMT_W-1:0] amt;
    } t_stack_op;

    typedef struct packed {
        logic [rms_pkg::VAL_W-1:0]   value;
        logic [rms_pkg::DEPTH_W-1:0] depth;
        logic [rms_pkg::ERR_W-1:0]   err;
    } t_stack_result;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic [rms_pkg::OP_W-1:0]    in_opcode = '0;
    logic [rms_pkg::VAL_W-1:0]   in_node = '0;
    logic [rms_pkg::AMT_W-1:0]   in_amount = '0;
    logic                        out_stall = 1'b0;
    logic                        in_stall;
    logic                        out_valid;
    logic [rms_pkg::VAL_W-1:0]   out_value;
    logic [rms_pkg::DEPTH_W-1:0] out_depth;
    logic [rms_pkg::ERR_W-1:0]   out_err;

    // Items waiting for the driver and results waiting for the monitor.
    t_stack_op     pending_ops[$];
    t_stack_result expected_results[$];
    t_stack_op     next_op;

    // Shadow stack updated at each accepted input transfer.
    logic [rms_pkg::VAL_W-1:0] shadow_mem [STACK_SIZE];
    int unsigned               shadow_depth = 0;

    // Depth as the generator sees it, used to aim amounts and to fill the stack.
    int unsigned gen_depth = 0;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        in_xfer = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    reduction_machine_stack DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (in_opcode),
        .i_node_ref   (in_node),
        .i_amount     (in_amount),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_read_value (out_value),
        .o_depth_now  (out_depth),
        .o_error_code (out_err)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic apply_stack_op(input logic [rms_pkg::OP_W-1:0] op,
                                  input logic [rms_pkg::VAL_W-1:0] node,
                                  input logic [rms_pkg::AMT_W-1:0] amt);
        t_stack_result res;
        res = '0;
        case (op)
            rms_pkg::OP_PUSH: begin
                if (shadow_depth >= STACK_SIZE) begin
                    res.err = rms_pkg::ERR_FULL;
                end else begin
                    shadow_mem[shadow_depth] = node;
                    shadow_depth++;
                end
            end
            rms_pkg::OP_POP: begin
                if (shadow_depth == 0) begin
                    res.err = rms_pkg::ERR_RANGE;
                end else begin
                    shadow_depth--;
                    res.value = shadow_mem[shadow_depth];
                end
            end
            rms_pkg::OP_PEEK: begin
                if (amt >= shadow_depth) res.err = rms_pkg::ERR_RANGE;
                else res.value = shadow_mem[shadow_depth - amt - 1];
            end
            rms_pkg::OP_POP_N: begin
                if (amt > shadow_depth) res.err = rms_pkg::ERR_RANGE;
                else shadow_depth -= amt;
            end
            rms_pkg::OP_SLIDE: begin
                if (amt >= shadow_depth) begin
                    res.err = rms_pkg::ERR_RANGE;
                end else begin
                    shadow_mem[shadow_depth - amt - 1] = shadow_mem[shadow_depth - 1];
                    shadow_depth -= amt;
                end
            end
            default: ;
        endcase
        res.depth = shadow_depth[rms_pkg::DEPTH_W-1:0];
        expected_results.push_back(res);
    endtask

    task automatic queue_op(input logic [rms_pkg::OP_W-1:0] op,
                            input logic [rms_pkg::VAL_W-1:0] node,
                            input int unsigned amt);
        t_stack_op item;
        item.op   = op;
        item.node = node;
        item.amt  = amt[rms_pkg::AMT_W-1:0];
        pending_ops.push_back(item);
        case (op)
            rms_pkg::OP_PUSH:  if (gen_depth < STACK_SIZE) gen_depth++;
            rms_pkg::OP_POP:   if (gen_depth > 0) gen_depth--;
            rms_pkg::OP_POP_N: if (item.amt <= gen_depth) gen_depth -= item.amt;
            rms_pkg::OP_SLIDE: if (item.amt < gen_depth) gen_depth -= item.amt;
            default: ;
        endcase
    endtask

    function automatic logic [rms_pkg::VAL_W-1:0] random_node();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return $urandom;
    endfunction

    // Mostly in-range amounts so that operations succeed; now and then any 9-bit value.
    function automatic int unsigned aim_amount(input int unsigned lim);
        if ($urandom_range(0, 9) == 0 || lim == 0) return $urandom_range(0, 511);
        if ($urandom_range(0, 3) != 0 && lim > 8) return $urandom_range(0, 7);
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic queue_random_ops(input int count);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 36) begin
                queue_op(rms_pkg::OP_PUSH, random_node(), $urandom_range(0, 511));
            end else if (pick < 50) begin
                queue_op(rms_pkg::OP_POP, random_node(), $urandom_range(0, 511));
            end else if (pick < 65) begin
                queue_op(rms_pkg::OP_PEEK, random_node(), aim_amount(gen_depth));
            end else if (pick < 75) begin
                queue_op(rms_pkg::OP_POP_N, random_node(), aim_amount(gen_depth + 1));
            end else if (pick < 89) begin
                queue_op(rms_pkg::OP_SLIDE, random_node(), aim_amount(gen_depth));
            end else if (pick < 94) begin
                queue_op(rms_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                         $urandom, $urandom_range(0, 511));
            end else begin
                queue_op(rms_pkg::OP_W'($urandom_range(rms_pkg::OP_PUSH, OP_SPARE_LAST)),
                         $urandom, $urandom_range(0, 511));
            end
        end
    endtask

    task automatic fill_stack();
        while (gen_depth < STACK_SIZE) queue_op(rms_pkg::OP_PUSH, random_node(), 0);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Driver: a new item is presented once the previous one has transferred.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_xfer) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                next_op = pending_ops.pop_front();
                in_valid  <= 1'b1;
                in_opcode <= next_op.op;
                in_node   <= next_op.node;
                in_amount <= next_op.amt;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off on request.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
            if (hold_left == 1) hold_done <= 1'b1;
        end else if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Monitor: results are checked before the same edge's input is predicted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %h depth %0d err %0d",
                                 out_value, out_depth, out_err);
                end else begin
                    t_stack_result want;
                    want = expected_results.pop_front();
                    if (out_value !== want.value || out_depth !== want.depth ||
                        out_err !== want.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                                     want.value, want.depth, want.err,
                                     out_value, out_depth, out_err);
                    end
                end
            end
            if (in_valid && !in_stall) apply_stack_op(in_opcode, in_node, in_amount);
        end
        in_xfer <= rst_n && in_valid && !in_stall;
    end

    always @(posedge clk) begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("reduction_machine_stack verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 19;
        rx_idle_pct = 75;
        // Errors on an empty stack, no-op pop_n and the unused opcodes.
        queue_op(rms_pkg::OP_POP, 32'h0, 0);
        queue_op(rms_pkg::OP_PEEK, 32'h0, 0);
        queue_op(rms_pkg::OP_SLIDE, 32'h0, 0);
        queue_op(rms_pkg::OP_POP_N, 32'h0, 0);
        queue_op(rms_pkg::OP_POP_N, 32'h0, 1);
        queue_op(OP_SPARE_FIRST, 32'hFFFF_FFFF, 511);
        queue_op(OP_SPARE_MID, 32'h1234_5678, 256);
        queue_op(OP_SPARE_LAST, 32'h8000_0001, 1);
        // Extreme references, peek at the edges and slide of zero.
        queue_op(rms_pkg::OP_PUSH, 32'h0000_0000, 0);
        queue_op(rms_pkg::OP_PUSH, 32'hFFFF_FFFF, 511);
        queue_op(rms_pkg::OP_PUSH, 32'h1234_5678, 0);
        queue_op(rms_pkg::OP_PUSH, 32'hA5A5_A5A5, 0);
        queue_op(rms_pkg::OP_PEEK, 32'h0, 0);
        queue_op(rms_pkg::OP_PEEK, 32'h0, 3);
        queue_op(rms_pkg::OP_PEEK, 32'h0, 4);
        queue_op(rms_pkg::OP_PEEK, 32'h0, 511);
        queue_op(rms_pkg::OP_SLIDE, 32'h0, 0);
        queue_op(rms_pkg::OP_SLIDE, 32'h0, 2);
        queue_op(rms_pkg::OP_PEEK, 32'h0, 1);
        queue_op(rms_pkg::OP_POP, 32'h0, 0);
        queue_op(rms_pkg::OP_POP, 32'h0, 0);
        queue_op(rms_pkg::OP_POP, 32'h0, 0);
        queue_op(rms_pkg::OP_PUSH, 32'h0000_0001, 0);
        queue_op(rms_pkg::OP_PUSH, 32'h0000_0002, 0);
        queue_op(rms_pkg::OP_POP_N, 32'h0, 2);
        queue_op(rms_pkg::OP_POP_N, 32'h0, 256);
        wait_drained();

        queue_random_ops(RANDOM_ITEMS);
        wait_drained();

        tx_idle_pct = 75;
        rx_idle_pct = 19;
        queue_random_ops(RANDOM_ITEMS);
        wait_drained();

        // The receiver holds off while the sender fills the stack back to back.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        fill_stack();
        queue_op(rms_pkg::OP_PUSH, random_node(), 0);
        queue_op(rms_pkg::OP_PUSH, random_node(), 0);
        queue_op(rms_pkg::OP_PEEK, 32'h0, 255);
        queue_op(rms_pkg::OP_PEEK, 32'h0, 256);
        queue_op(rms_pkg::OP_SLIDE, 32'h0, 256);
        queue_op(rms_pkg::OP_SLIDE, 32'h0, 255);
        fill_stack();
        queue_op(rms_pkg::OP_POP_N, 32'h0, 257);
        queue_op(rms_pkg::OP_POP_N, 32'h0, 256);
        queue_random_ops(RANDOM_ITEMS);
        wait_drained();
        hold_req = 1'b0;

        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("reduction_machine_stack verification clean");
        end else begin
            $display("reduction_machine_stack verification failed");
        end
        $finish;
    end

endmodule
